### src/sle_pkg.sv
// Shared types and codes for the sorted list engine.
// No dependencies; used by sle_cell and sorted_list_engine_top.
package sle_pkg;

  localparam int unsigned ValW = 31;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE_MAX = 2'd2,
    OP_REMOVE_VAL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic            valid;
    logic [ValW-1:0] entry;
  } cell_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic            apply;
    op_e             op;
    logic [ValW-1:0] value;
  } cmd_t;

endpackage

### src/sorted_list_engine_top.sv
// Top level of the sorted list engine: a row of sle_cell slots and a result register.
// Depends on sle_pkg and sle_cell.
//
// Keeps up to DEPTH values in ascending order in a row of cells. Each input beat
// carries one operation (insert, remove smallest, remove largest, remove a given
// value) and yields exactly one result beat with a status and the removed value.
// Every cell compares its entry with the broadcast value and, as the result is
// registered, takes its own, its left or right neighbor's entry, the value or an
// empty slot. A new beat is taken whenever the result register is empty or its
// beat is taken by the output side. There is no clearing pass after reset.
module sorted_list_engine_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [sle_pkg::ValW-1:0] item_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [sle_pkg::ValW-1:0] removed_value_o
);

  sle_pkg::cell_t cells [DEPTH];
  sle_pkg::cell_t lefts [DEPTH];
  sle_pkg::cell_t rights[DEPTH];
  logic [DEPTH-1:0] le, eq, left_le;

  sle_pkg::cmd_t    cmd;
  sle_pkg::op_e     op;
  logic             accept;
  logic             full, empty, found;
  logic [sle_pkg::ValW-1:0] max_value;
  sle_pkg::status_e status;
  logic [sle_pkg::ValW-1:0] removed;

  logic                     out_valid_q, out_valid_d;
  logic [1:0]               status_q;
  logic [sle_pkg::ValW-1:0] removed_q;

  assign op         = sle_pkg::op_e'(operation_i);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = cells[DEPTH-1].valid;
  assign empty = !cells[0].valid;
  assign found = |eq;

  always_comb begin
    max_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cells[i].valid && ((i == DEPTH - 1) || !cells[(i + 1) % DEPTH].valid)) begin
        max_value = max_value | cells[i].entry;
      end
    end
  end

  always_comb begin
    status  = sle_pkg::ST_OK;
    removed = '0;
    case (op)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status = sle_pkg::ST_FULL;
        end
      end
      sle_pkg::OP_REMOVE_MIN: begin
        if (empty) begin
          status = sle_pkg::ST_EMPTY;
        end else begin
          removed = cells[0].entry;
        end
      end
      sle_pkg::OP_REMOVE_MAX: begin
        if (empty) begin
          status = sle_pkg::ST_EMPTY;
        end else begin
          removed = max_value;
        end
      end
      sle_pkg::OP_REMOVE_VAL: begin
        if (empty) begin
          status = sle_pkg::ST_EMPTY;
        end else if (!found) begin
          status = sle_pkg::ST_NOT_FOUND;
        end else begin
          removed = item_value_i;
        end
      end
      default: begin
        status = sle_pkg::ST_OK;
      end
    endcase
  end

  assign cmd.apply = accept && (status == sle_pkg::ST_OK);
  assign cmd.op    = op;
  assign cmd.value = item_value_i;

  for (genvar g = 0; g < DEPTH; g++) begin : g_row
    if (g == 0) begin : g_head
      assign lefts[g]   = '0;
      assign left_le[g] = 1'b1;
    end else begin : g_body
      assign lefts[g]   = cells[g-1];
      assign left_le[g] = le[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign rights[g] = '0;
    end else begin : g_mid
      assign rights[g] = cells[g+1];
    end

    sle_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (lefts[g]),
      .left_le_i (left_le[g]),
      .right_i   (rights[g]),
      .self_o    (cells[g]),
      .le_o      (le[g]),
      .eq_o      (eq[g])
    );
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status;
      removed_q <= removed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;

endmodule

### src/sle_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
// Depends on sle_pkg.
module sle_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sle_pkg::cmd_t cmd_i,
  input  sle_pkg::cell_t left_i,
  input  logic          left_le_i,
  input  sle_pkg::cell_t right_i,
  output sle_pkg::cell_t self_o,
  output logic          le_o,
  output logic          eq_o
);

  sle_pkg::cell_t cell_q, cell_d;
  logic           ge;

  assign self_o = cell_q;
  assign le_o   = cell_q.valid && (cell_q.entry <= cmd_i.value);
  assign ge     = cell_q.valid && (cell_q.entry >= cmd_i.value);
  assign eq_o   = cell_q.valid && (cell_q.entry == cmd_i.value);

  always_comb begin
    cell_d = cell_q;
    if (cmd_i.apply) begin
      case (cmd_i.op)
        sle_pkg::OP_INSERT: begin
          if (le_o) begin
            cell_d = cell_q;
          end else if (left_le_i) begin
            cell_d.valid = 1'b1;
            cell_d.entry = cmd_i.value;
          end else begin
            cell_d = left_i;
          end
        end
        sle_pkg::OP_REMOVE_MIN: begin
          cell_d = right_i;
        end
        sle_pkg::OP_REMOVE_MAX: begin
          if (cell_q.valid && !right_i.valid) begin
            cell_d = '0;
          end
        end
        sle_pkg::OP_REMOVE_VAL: begin
          if (ge) begin
            cell_d = right_i;
          end
        end
        default: begin
          cell_d = cell_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

endmodule
